@@ src/rfd_pkg.sv @@
// Shared types and constants for the rangefinder frame decoder.
// No dependencies; compiled first.
`default_nettype none

package rfd_pkg;

  localparam int ANGLE_W = 17;

  localparam logic [7:0] HDR_SINGLE = 8'hFF;  // header of scanning and single frames
  localparam logic [7:0] HDR_MULTI  = 8'h7F;  // header of multi-sensor frames
  localparam logic [7:0] END_FLAG   = 8'h03;  // byte 8 of a multi-sensor frame
  localparam logic [7:0] CMD_POLL   = 8'h12;

  // configuration register indexes
  localparam logic [7:0] CFG_MODE_COUNT = 8'd0;
  localparam logic [7:0] CFG_MAX_RANGE  = 8'd1;

  typedef struct packed {
    logic                      valid;
    logic [15:0]               distance_cm;
    logic signed [ANGLE_W-1:0] angle_cdeg;
    logic [7:0]                sensor_id;
    logic                      out_of_range;
  } reading_t;

  // mounting angle of each sensor in a multi-sensor ring
  function automatic logic signed [ANGLE_W-1:0] angle_of_id(input logic [7:0] id);
    logic signed [ANGLE_W-1:0] a;
    case (id)
      8'd1:    a = 17'sd4500;
      8'd2:    a = 17'sd1500;
      8'd3:    a = -17'sd1500;
      8'd4:    a = -17'sd4500;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ src/rfd_ifs.sv @@
// Channel interfaces of the rangefinder frame decoder: input items,
// result items and configuration writes. Depends on rfd_pkg.
`default_nettype none

interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface rfd_out_if import rfd_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      out_kind;
  logic [7:0]                tx_byte;
  logic                      tx_last;
  logic [15:0]               distance_cm;
  logic signed [ANGLE_W-1:0] angle_cdeg;
  logic [7:0]                sensor_id;
  logic                      out_of_range;

  modport source (output valid, out_kind, tx_byte, tx_last, distance_cm, angle_cdeg,
                  sensor_id, out_of_range, input ready);
  modport sink   (input valid, out_kind, tx_byte, tx_last, distance_cm, angle_cdeg,
                  sensor_id, out_of_range, output ready);
endinterface

interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ src/rangefinder_frame_decoder.sv @@
// Rangefinder frame decoder top level: configuration registers, poll
// request generator and result register. Depends on rfd_pkg, rfd_ifs, rfd_parser.
//
//  channel  | dir | payload                                        | accepted when
//  items    | in  | kind, rx_byte                                  | valid & ready
//  results  | out | out_kind, tx_byte, tx_last, distance_cm,       | valid & ready
//           |     | angle_cdeg, sensor_id, out_of_range            |
//  cfg      | in  | addr, data                                     | valid & ready (ready = 1)
//
// A byte is decoded in the cycle it is accepted; a reading shows on results the
// next cycle. One item per cycle while results are taken and no command burst runs.
// A poll in multi-sensor mode yields ten command bytes; items are held off until
// the last one is in the result register.
// Synchronous reset: mode 1, max range 700 cm, poll cursor 1, no partial frame.
// A stalled result stalls items; the result register frees when taken.
`default_nettype none

module rangefinder_frame_decoder
  import rfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  rfd_in_if.sink    items,
  rfd_out_if.source results,
  rfd_cfg_if.sink   cfg
);

  logic [7:0]  mode_count;
  logic [15:0] max_range_cm;
  logic [7:0]  poll_cursor;
  logic        burst_active;
  logic [3:0]  burst_idx;
  logic [7:0]  burst_id;

  logic                      out_valid;
  logic                      out_kind;
  logic [7:0]                tx_byte;
  logic                      tx_last;
  logic [15:0]               distance_cm;
  logic signed [ANGLE_W-1:0] angle_cdeg;
  logic [7:0]                sensor_id;
  logic                      out_of_range;

  logic       slot_free, in_acc, byte_en, poll_go, burst_step;
  logic [7:0] cur;
  reading_t   reading;

  function automatic logic [7:0] cmd_byte(input logic [3:0] idx, input logic [7:0] id);
    logic [7:0] b;
    case (idx)
      4'd0:    b = HDR_MULTI;
      4'd1:    b = id;
      4'd2:    b = CMD_POLL;
      4'd8:    b = END_FLAG;
      4'd9:    b = id + CMD_POLL + END_FLAG;
      default: b = '0;
    endcase
    return b;
  endfunction

  assign slot_free   = !out_valid || results.ready;
  assign items.ready = !burst_active && slot_free;
  assign in_acc      = items.valid && items.ready;
  assign byte_en     = in_acc && !items.kind;
  assign poll_go     = in_acc && items.kind && (mode_count >= 8'd2);
  assign burst_step  = burst_active && slot_free;
  assign cur         = (poll_cursor > mode_count) ? 8'd1 : poll_cursor;
  assign cfg.ready   = 1'b1;

  rfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_en      (byte_en),
    .rx_byte      (items.rx_byte),
    .mode_count   (mode_count),
    .max_range_cm (max_range_cm),
    .reading      (reading)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count   <= 8'd1;
      max_range_cm <= 16'd700;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_MODE_COUNT: mode_count   <= cfg.data[7:0];
        CFG_MAX_RANGE:  max_range_cm <= cfg.data;
        default: ;
      endcase
    end
  end

  // poll burst control
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_cursor  <= 8'd1;
      burst_active <= 1'b0;
      burst_idx    <= '0;
      burst_id     <= '0;
    end else if (poll_go) begin
      poll_cursor  <= cur + 8'd1;
      burst_active <= 1'b1;
      burst_idx    <= 4'd1;
      burst_id     <= cur;
    end else if (burst_step) begin
      burst_idx <= burst_idx + 4'd1;
      if (burst_idx == 4'd9) begin
        burst_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (poll_go || burst_step || reading.valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_go || burst_step) begin
      out_kind     <= 1'b1;
      tx_byte      <= poll_go ? cmd_byte(4'd0, cur) : cmd_byte(burst_idx, burst_id);
      tx_last      <= !poll_go && (burst_idx == 4'd9);
      distance_cm  <= '0;
      angle_cdeg   <= '0;
      sensor_id    <= '0;
      out_of_range <= 1'b0;
    end else if (reading.valid) begin
      out_kind     <= 1'b0;
      tx_byte      <= '0;
      tx_last      <= 1'b0;
      distance_cm  <= reading.distance_cm;
      angle_cdeg   <= reading.angle_cdeg;
      sensor_id    <= reading.sensor_id;
      out_of_range <= reading.out_of_range;
    end
  end

  assign results.valid        = out_valid;
  assign results.out_kind     = out_kind;
  assign results.tx_byte      = tx_byte;
  assign results.tx_last      = tx_last;
  assign results.distance_cm  = distance_cm;
  assign results.angle_cdeg   = angle_cdeg;
  assign results.sensor_id    = sensor_id;
  assign results.out_of_range = out_of_range;

`ifndef SYNTHESIS
  a_no_items_in_burst: assert property (@(posedge clk) burst_active |-> !items.ready)
    else $error("item accepted during command burst");

  a_poll_starts_burst: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.kind && mode_count >= 8'd2)
      |=> (burst_active && results.valid && results.out_kind))
    else $error("poll did not start a command burst");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.tx_last) |-> !burst_active)
    else $error("last command byte shown while burst still running");
`endif

endmodule

`default_nettype wire

@@ src/rfd_parser.sv @@
// Frame assembler and decoder: collects received bytes, keeps a running
// checksum and decodes a completed frame in the cycle of its last byte.
// Depends on rfd_pkg.
`default_nettype none

module rfd_parser
  import rfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_en,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  mode_count,
  input  wire logic [15:0] max_range_cm,
  output reading_t         reading
);

  logic [7:0] frame_bytes [10];
  logic [3:0] byte_count, byte_count_next;
  logic [7:0] sum_acc, sum_acc_next;
  logic       wr_en, done;

  logic        multi;
  logic [3:0]  frame_len;
  logic [7:0]  hdr;
  logic [15:0] raw;
  logic [31:0] prod;
  logic [16:0] sub_sum;
  logic [15:0] substitute;
  logic        oor, ck_ok, flag_ok;

  assign multi     = (mode_count >= 8'd2);
  assign frame_len = (mode_count == 8'd0) ? 4'd6 : ((mode_count == 8'd1) ? 4'd4 : 4'd10);
  assign hdr       = multi ? HDR_MULTI : HDR_SINGLE;

  always_comb begin
    byte_count_next = byte_count;
    sum_acc_next    = sum_acc;
    wr_en           = 1'b0;
    done            = 1'b0;
    if (byte_en) begin
      if (byte_count >= frame_len) begin
        // mode changed under a partial frame: drop it and this byte
        byte_count_next = '0;
      end else if (byte_count == 4'd0) begin
        if (rx_byte == hdr) begin
          byte_count_next = 4'd1;
          sum_acc_next    = '0;
          wr_en           = 1'b1;
        end
      end else begin
        wr_en = 1'b1;
        if (byte_count + 4'd1 == frame_len) begin
          byte_count_next = '0;
          done            = 1'b1;
        end else begin
          byte_count_next = byte_count + 4'd1;
          sum_acc_next    = sum_acc + rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      sum_acc    <= '0;
    end else begin
      byte_count <= byte_count_next;
      sum_acc    <= sum_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_bytes[byte_count] <= rx_byte;
    end
  end

  // decode; the checksum byte is the incoming one
  assign ck_ok   = (rx_byte == sum_acc);
  assign flag_ok = !multi || (frame_bytes[8] == END_FLAG);
  assign raw     = multi ? {frame_bytes[4], frame_bytes[5]} : {frame_bytes[1], frame_bytes[2]};
  assign prod    = raw * 16'hCCCD;  // (x * 0xCCCD) >> 19 == x / 10 for 16-bit x
  assign oor     = (raw >= 16'd7000);

  assign sub_sum    = {1'b0, max_range_cm} + 17'd100;
  assign substitute = sub_sum[16] ? 16'hFFFF
                    : ((sub_sum[15:0] < 16'd800) ? 16'd800 : sub_sum[15:0]);

  always_comb begin
    reading.valid        = done && ck_ok && flag_ok;
    reading.out_of_range = oor;
    reading.distance_cm  = oor ? substitute : {3'b000, prod[31:19]};
    if (mode_count == 8'd0) begin
      reading.angle_cdeg = $signed({1'b0, frame_bytes[3], frame_bytes[4]});
      reading.sensor_id  = '0;
    end else if (multi) begin
      reading.angle_cdeg = angle_of_id(frame_bytes[1]);
      reading.sensor_id  = frame_bytes[1];
    end else begin
      reading.angle_cdeg = '0;
      reading.sensor_id  = '0;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_rangefinder_frame_decoder.sv @@
// Self-checking testbench for rangefinder_frame_decoder: random and directed
// byte/poll traffic, an in-bench decoder model and an in-order scoreboard.
// Depends on rfd_pkg, rfd_ifs and the decoder RTL.

module tb_rangefinder_frame_decoder;
  import rfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_POLL   = 1'b1;
  localparam logic OUT_READING = 1'b0;
  localparam logic OUT_COMMAND = 1'b1;

  localparam logic [7:0] MODE_SCAN      = 8'd0;
  localparam logic [7:0] MODE_SINGLE    = 8'd1;
  localparam logic [7:0] MODE_MULTI_MIN = 8'd2;

  localparam int IDLE_PCT     = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT  = 3000;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                      out_kind;
    logic [7:0]                tx_byte;
    logic                      tx_last;
    logic [15:0]               distance_cm;
    logic signed [ANGLE_W-1:0] angle_cdeg;
    logic [7:0]                sensor_id;
    logic                      out_of_range;
  } decoded_t;

  logic clk;
  logic rst;

  rfd_in_if  items_if ();
  rfd_out_if results_if ();
  rfd_cfg_if cfg_if ();

  rangefinder_frame_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  item_t    items_to_send[$];
  decoded_t results_owed[$];

  // decoder model state
  logic [7:0]  mode_reg   = MODE_SINGLE;
  logic [15:0] range_reg  = 16'd700;
  logic [7:0]  frame_buf [10];
  int          frame_fill = 0;
  logic [7:0]  next_sensor = 8'd1;

  int  fails         = 0;
  bit  steady        = 1'b0;
  int  holds_wanted  = 0;
  int  holds_given   = 0;
  int  hold_left     = 0;
  int  quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Model of one accepted item: updates the frame state and queues the outputs it owes.
  task automatic decode_item(input logic kind, input logic [7:0] b);
    int          len;
    int          subst;
    logic [7:0]  ck;
    logic [7:0]  hdr;
    logic [15:0] raw;
    logic [15:0] dist_cm;
    logic        good;
    decoded_t    r;
    len = (mode_reg == MODE_SCAN) ? 6 : (mode_reg == MODE_SINGLE) ? 4 : 10;
    if (kind == KIND_POLL) begin
      if (mode_reg < MODE_MULTI_MIN) return;
      if (next_sensor > mode_reg) next_sensor = 8'd1;
      ck = next_sensor + CMD_POLL + END_FLAG;
      for (int i = 0; i < 10; i++) begin
        r = '0;
        r.out_kind = OUT_COMMAND;
        r.tx_last  = (i == 9);
        case (i)
          0:       r.tx_byte = HDR_MULTI;
          1:       r.tx_byte = next_sensor;
          2:       r.tx_byte = CMD_POLL;
          8:       r.tx_byte = END_FLAG;
          9:       r.tx_byte = ck;
          default: r.tx_byte = 8'h00;
        endcase
        results_owed.push_back(r);
      end
      next_sensor = next_sensor + 8'd1;
      return;
    end
    // mode shrank under a partial frame: drop it and the byte
    if (frame_fill >= len) begin
      frame_fill = 0;
      return;
    end
    if (frame_fill == 0) begin
      hdr = (mode_reg < MODE_MULTI_MIN) ? HDR_SINGLE : HDR_MULTI;
      if (b == hdr) begin
        frame_buf[0] = b;
        frame_fill = 1;
      end
      return;
    end
    frame_buf[frame_fill] = b;
    frame_fill++;
    if (frame_fill != len) return;
    frame_fill = 0;
    r = '0;
    r.out_kind = OUT_READING;
    ck = '0;
    for (int i = 1; i < len - 1; i++) ck += frame_buf[i];
    good = (ck == frame_buf[len-1]);
    if (mode_reg == MODE_SCAN) begin
      raw = {frame_buf[1], frame_buf[2]};
      r.angle_cdeg = {1'b0, frame_buf[3], frame_buf[4]};
      r.out_of_range = (raw >= 16'd7000);
      dist_cm = raw / 16'd10;
    end else if (mode_reg == MODE_SINGLE) begin
      raw = {frame_buf[1], frame_buf[2]};
      r.out_of_range = (raw >= 16'd7000);
      dist_cm = raw / 16'd10;
    end else begin
      good = good && (frame_buf[8] == END_FLAG);
      dist_cm = {frame_buf[4], frame_buf[5]} / 16'd10;
      r.sensor_id = frame_buf[1];
      r.out_of_range = (dist_cm >= 16'd700);
      case (frame_buf[1])
        8'd1:    r.angle_cdeg = 17'sd4500;
        8'd2:    r.angle_cdeg = 17'sd1500;
        8'd3:    r.angle_cdeg = -17'sd1500;
        8'd4:    r.angle_cdeg = -17'sd4500;
        default: r.angle_cdeg = '0;
      endcase
    end
    if (!good) return;
    if (r.out_of_range) begin
      subst = int'(range_reg) + 100;
      if (subst < 800) subst = 800;
      if (subst > 65535) subst = 65535;
      dist_cm = subst[15:0];
    end
    r.distance_cm = dist_cm;
    results_owed.push_back(r);
  endtask

  function automatic void push_item(input logic kind, input logic [7:0] b);
    item_t it;
    it.kind = kind;
    it.rx_byte = b;
    items_to_send.push_back(it);
  endfunction

  // Queues one frame in the format of the current mode; returns its length.
  function automatic int queue_frame(input bit bad_ck, input bit no_end,
                                     input logic [15:0] raw, input logic [15:0] ang,
                                     input logic [7:0] id);
    logic [7:0] fb [10];
    int         len;
    logic [7:0] ck;
    if (mode_reg == MODE_SCAN) begin
      len = 6;
      fb[0] = HDR_SINGLE;
      fb[1] = raw[15:8];
      fb[2] = raw[7:0];
      fb[3] = ang[15:8];
      fb[4] = ang[7:0];
    end else if (mode_reg == MODE_SINGLE) begin
      len = 4;
      fb[0] = HDR_SINGLE;
      fb[1] = raw[15:8];
      fb[2] = raw[7:0];
    end else begin
      len = 10;
      fb[0] = HDR_MULTI;
      fb[1] = id;
      fb[2] = $urandom;
      fb[3] = $urandom;
      fb[4] = raw[15:8];
      fb[5] = raw[7:0];
      fb[6] = $urandom;
      fb[7] = $urandom;
      fb[8] = no_end ? (END_FLAG ^ 8'($urandom_range(1, 255))) : END_FLAG;
    end
    ck = '0;
    for (int i = 1; i < len - 1; i++) ck += fb[i];
    if (bad_ck) ck ^= 8'($urandom_range(1, 255));
    fb[len-1] = ck;
    for (int i = 0; i < len; i++) push_item(KIND_BYTE, fb[i]);
    return len;
  endfunction

  // Mostly well-formed frames with random content; some polls, noise and broken frames.
  task automatic random_traffic(input int n);
    int          made;
    int          r;
    logic [15:0] raw;
    logic [15:0] ang;
    logic [7:0]  id;
    logic [7:0]  hdr;
    made = 0;
    hdr = (mode_reg < MODE_MULTI_MIN) ? HDR_SINGLE : HDR_MULTI;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_item(KIND_POLL, 8'($urandom));
        if (mode_reg >= MODE_MULTI_MIN) made++;
      end else if (r < 20) begin
        push_item(KIND_BYTE, (r < 13) ? hdr : 8'($urandom_range(255)));
        made++;
      end else begin
        case ($urandom_range(5))
          0:       raw = 16'd0;
          1:       raw = 16'd6999;
          2:       raw = 16'd7000;
          3:       raw = 16'hFFFF;
          default: raw = 16'($urandom_range(9000));
        endcase
        if ($urandom_range(3) == 0) ang = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else ang = 16'($urandom);
        id = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
        made += queue_frame($urandom_range(99) < 12, $urandom_range(99) < 8, raw, ang, id);
      end
    end
    // sometimes leave a partial frame behind for the next setting
    if ($urandom_range(1) == 1) begin
      push_item(KIND_BYTE, hdr);
      repeat ($urandom_range(3)) push_item(KIND_BYTE, 8'($urandom));
    end
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_MODE_COUNT) mode_reg = val[7:0];
    else if (idx == CFG_MAX_RANGE) range_reg = val;
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (items_to_send.size() != 0 || items_if.valid || results_owed.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // item driver
  always @(posedge clk) begin : drive_items
    item_t nxt;
    if (rst) begin
      items_if.valid <= 1'b0;
    end else begin
      if (items_if.valid && items_if.ready) decode_item(items_if.kind, items_if.rx_byte);
      if (!items_if.valid || items_if.ready) begin
        if (items_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = items_to_send.pop_front();
          items_if.valid   <= 1'b1;
          items_if.kind    <= nxt.kind;
          items_if.rx_byte <= nxt.rx_byte;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk) begin : check_results
    decoded_t got;
    decoded_t want;
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        got = '{results_if.out_kind, results_if.tx_byte, results_if.tx_last,
                results_if.distance_cm, results_if.angle_cdeg, results_if.sensor_id,
                results_if.out_of_range};
        if (results_owed.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected result kind=%0d tx=%h last=%0d dist=%0d ang=%0d id=%0d oor=%0d",
                     $time, got.out_kind, got.tx_byte, got.tx_last, got.distance_cm,
                     got.angle_cdeg, got.sensor_id, got.out_of_range);
        end else begin
          want = results_owed.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("%0t: result mismatch", $time);
              $display("  expected kind=%0d tx=%h last=%0d dist=%0d ang=%0d id=%0d oor=%0d",
                       want.out_kind, want.tx_byte, want.tx_last, want.distance_cm,
                       want.angle_cdeg, want.sensor_id, want.out_of_range);
              $display("  actual   kind=%0d tx=%h last=%0d dist=%0d ang=%0d id=%0d oor=%0d",
                       got.out_kind, got.tx_byte, got.tx_last, got.distance_cm,
                       got.angle_cdeg, got.sensor_id, got.out_of_range);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else if (holds_given != holds_wanted) begin
        holds_given++;
        hold_left = HOLD_CYCLES;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst) begin
      if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : run
    int polls;
    items_if.valid     = 1'b0;
    items_if.kind      = KIND_BYTE;
    items_if.rx_byte   = 8'h00;
    results_if.ready   = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.addr        = CFG_MODE_COUNT;
    cfg_if.data        = 16'h0000;
    for (int i = 0; i < 10; i++) frame_buf[i] = 8'h00;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // single-sensor defaults: range edge, saturated raw, ignored poll, bad checksum
    void'(queue_frame(1'b0, 1'b0, 16'd6999, 16'h0000, 8'd0));
    push_item(KIND_POLL, 8'hFF);
    void'(queue_frame(1'b0, 1'b0, 16'hFFFF, 16'h0000, 8'd0));
    void'(queue_frame(1'b1, 1'b0, 16'd1234, 16'h0000, 8'd0));
    drain_all();

    // two sensors, zero max range; third poll wraps the cursor back to sensor 1
    write_reg(CFG_MODE_COUNT, 16'(MODE_MULTI_MIN));
    write_reg(CFG_MAX_RANGE, 16'd0);
    void'(queue_frame(1'b0, 1'b0, 16'd7000, 16'h0000, 8'd4));
    repeat (3) push_item(KIND_POLL, 8'h00);
    drain_all();

    write_reg(CFG_MODE_COUNT, 16'(MODE_SCAN));
    write_reg(CFG_MAX_RANGE, 16'd65000);
    random_traffic(20);
    drain_all();

    // no idling on either side here
    steady = 1'b1;
    write_reg(CFG_MODE_COUNT, 16'(MODE_SINGLE));
    write_reg(CFG_MAX_RANGE, 16'd750);
    random_traffic(15);
    drain_all();
    steady = 1'b0;

    // receiver stalls long while items keep coming; ends on a long partial frame
    write_reg(CFG_MODE_COUNT, 16'd2);
    write_reg(CFG_MAX_RANGE, 16'd1234);
    holds_wanted++;
    random_traffic(30);
    push_item(KIND_BYTE, HDR_MULTI);
    repeat (7) push_item(KIND_BYTE, 8'($urandom));
    drain_all();

    // shorter frame format now: the next byte discards the stale partial frame
    write_reg(CFG_MODE_COUNT, 16'(MODE_SCAN));
    random_traffic(10);
    drain_all();

    // full sensor count: poll until the cursor wraps through 255 and 0
    write_reg(CFG_MODE_COUNT, 16'd255);
    write_reg(CFG_MAX_RANGE, 16'd300);
    polls = ((256 - int'(next_sensor)) % 256) + 3;
    for (int i = 0; i < polls; i++) push_item(KIND_POLL, 8'($urandom));
    drain_all();

    write_reg(CFG_MODE_COUNT, 16'd3);
    write_reg(CFG_MAX_RANGE, 16'd7000);
    random_traffic(15);
    drain_all();

    if (fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
